// File: design/ggvc_pkg.sv
// Shared types, constants and register codes of the go-to-goal velocity controller.
package ggvc_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int SQRT_STEPS   = 25;
    localparam int ITER_STAGES  = SQRT_STEPS;
    localparam int LATENCY      = ITER_STAGES + 7;

    localparam int XY_W = 36;
    localparam int Z_W  = 35;
    localparam int SQ_W = 50;

    localparam logic signed [Z_W-1:0] PI_Z30     = 35'sd3373259426;
    localparam logic signed [18:0]    PI_Q13     = 19'sd25736;
    localparam logic signed [18:0]    TWO_PI_Q13 = 19'sd51472;

    localparam logic signed [Z_W-1:0] ATAN_Z30 [0:23] = '{
        35'sd843314857, 35'sd497837829, 35'sd263043837, 35'sd133525159,
        35'sd67021687,  35'sd33543516,  35'sd16775851,  35'sd8388437,
        35'sd4194283,   35'sd2097149,   35'sd1048576,   35'sd524288,
        35'sd262144,    35'sd131072,    35'sd65536,     35'sd32768,
        35'sd16384,     35'sd8192,      35'sd4096,      35'sd2048,
        35'sd1024,      35'sd512,       35'sd256,       35'sd128
    };

    typedef enum logic [2:0] {
        REG_GOAL_X          = 3'd0,
        REG_GOAL_Y          = 3'd1,
        REG_POSITION_MARGIN = 3'd2,
        REG_HEADING_MARGIN  = 3'd3,
        REG_ANGULAR_GAIN    = 3'd4,
        REG_LINEAR_GAIN     = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic signed [23:0] goal_x;
        logic signed [23:0] goal_y;
        logic [15:0]        position_margin;
        logic [13:0]        heading_margin;
        logic [15:0]        angular_gain;
        logic [15:0]        linear_gain;
    } cfg_t;

    typedef struct packed {
        logic signed [23:0] pose_x;
        logic signed [23:0] pose_y;
        logic signed [15:0] heading;
    } pose_t;

    typedef struct packed {
        logic signed [23:0] linear_velocity;
        logic signed [15:0] angular_velocity;
        logic               arrived;
    } cmd_t;

endpackage

// File: design/go_to_goal_velocity_controller.sv
// Top level: pipelined go-to-goal controller (CORDIC bearing, square-root distance).
// A pose is taken in every cycle and never refused (busy stays low). Its command
// reaches result, with done high, after stages A, B, the iteration stages, D, E,
// F and G (the output register); the depth is set by the 25-stage bit-per-stage
// square root that runs beside the 16-stage CORDIC. Results cannot be held off.
// Registers are written through cfg_valid/cfg_index/cfg_data (always ready); the user
// must write them only while no pose is in flight, which the block does not enforce.
module go_to_goal_velocity_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  ggvc_pkg::pose_t     pose,
    output logic                done,
    output ggvc_pkg::cmd_t      result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [23:0]         cfg_data
);

    localparam int ITER = ggvc_pkg::ITER_STAGES;
    localparam int XW   = ggvc_pkg::XY_W;
    localparam int ZW   = ggvc_pkg::Z_W;
    localparam int QW   = ggvc_pkg::SQ_W;

    ggvc_pkg::cfg_t cfg;

    ggvc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // ---------------- stage A: position errors
    logic               a_vld_reg;
    logic signed [24:0] a_dx_reg, a_dy_reg;
    logic signed [15:0] a_head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else
            a_vld_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        a_dx_reg   <= {cfg.goal_x[23], cfg.goal_x} - {pose.pose_x[23], pose.pose_x};
        a_dy_reg   <= {cfg.goal_y[23], cfg.goal_y} - {pose.pose_y[23], pose.pose_y};
        a_head_reg <= pose.heading;
    end

    // ---------------- stage B: arrival test, CORDIC entry, squares
    logic [24:0]          b_adx, b_ady;
    logic signed [XW-1:0] b_x0, b_y0;
    logic signed [49:0]   b_sqx, b_sqy;

    logic                 b_vld_reg, b_arr_reg, b_zero_reg;
    logic signed [XW-1:0] b_x_reg, b_y_reg;
    logic signed [ZW-1:0] b_z_reg;
    logic [48:0]          b_sqx_reg, b_sqy_reg;
    logic signed [15:0]   b_head_reg;

    always_comb
    begin
        b_adx = a_dx_reg[24] ? 25'(-a_dx_reg) : 25'(a_dx_reg);
        b_ady = a_dy_reg[24] ? 25'(-a_dy_reg) : 25'(a_dy_reg);
        b_x0  = XW'(a_dx_reg) <<< 8;
        b_y0  = XW'(a_dy_reg) <<< 8;
        b_sqx = a_dx_reg * a_dx_reg;
        b_sqy = a_dy_reg * a_dy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_vld_reg <= 1'b0;
        else
            b_vld_reg <= a_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        b_arr_reg  <= (b_adx < {9'd0, cfg.position_margin}) &&
                      (b_ady < {9'd0, cfg.position_margin});
        b_zero_reg <= (a_dx_reg == '0) && (a_dy_reg == '0);
        // left half-plane: rotate by pi first
        if (a_dx_reg[24])
        begin
            b_x_reg <= -b_x0;
            b_y_reg <= -b_y0;
            b_z_reg <= a_dy_reg[24] ? -ggvc_pkg::PI_Z30 : ggvc_pkg::PI_Z30;
        end
        else
        begin
            b_x_reg <= b_x0;
            b_y_reg <= b_y0;
            b_z_reg <= '0;
        end
        b_sqx_reg  <= b_sqx[48:0];
        b_sqy_reg  <= b_sqy[48:0];
        b_head_reg <= a_head_reg;
    end

    // ---------------- iteration stages: one root bit each, and a CORDIC step in the first CORDIC_STEPS of them
    logic                 it_vld_reg  [0:ITER];
    logic                 it_arr_reg  [0:ITER];
    logic                 it_zero_reg [0:ITER];
    logic signed [XW-1:0] it_x_reg    [0:ITER];
    logic signed [XW-1:0] it_y_reg    [0:ITER];
    logic signed [ZW-1:0] it_z_reg    [0:ITER];
    logic [QW-1:0]        it_rem_reg  [0:ITER];
    logic [QW-1:0]        it_root_reg [0:ITER];
    logic signed [15:0]   it_head_reg [0:ITER];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            it_vld_reg[0] <= 1'b0;
        else
            it_vld_reg[0] <= b_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        it_arr_reg[0]  <= b_arr_reg;
        it_zero_reg[0] <= b_zero_reg;
        it_x_reg[0]    <= b_x_reg;
        it_y_reg[0]    <= b_y_reg;
        it_z_reg[0]    <= b_z_reg;
        it_rem_reg[0]  <= {1'b0, b_sqx_reg} + {1'b0, b_sqy_reg};
        it_root_reg[0] <= '0;
        it_head_reg[0] <= b_head_reg;
    end

    for (genvar k = 0; k < ITER; k++)
    begin : g_iter
        localparam logic [QW:0] BIT = (QW+1)'(1) << (2 * (ITER - 1 - k));

        logic signed [XW-1:0] x_next, y_next;
        logic signed [ZW-1:0] z_next;
        logic [QW:0]          trial;
        logic [QW-1:0]        rem_next, root_next;

        if (k < ggvc_pkg::CORDIC_STEPS)
        begin : g_rot
            always_comb
            begin
                if (!it_y_reg[k][XW-1])
                begin
                    x_next = it_x_reg[k] + (it_y_reg[k] >>> k);
                    y_next = it_y_reg[k] - (it_x_reg[k] >>> k);
                    z_next = it_z_reg[k] + ggvc_pkg::ATAN_Z30[k];
                end
                else
                begin
                    x_next = it_x_reg[k] - (it_y_reg[k] >>> k);
                    y_next = it_y_reg[k] + (it_x_reg[k] >>> k);
                    z_next = it_z_reg[k] - ggvc_pkg::ATAN_Z30[k];
                end
            end
        end
        else
        begin : g_pass
            always_comb
            begin
                x_next = it_x_reg[k];
                y_next = it_y_reg[k];
                z_next = it_z_reg[k];
            end
        end

        always_comb
        begin
            trial = {1'b0, it_root_reg[k]} + BIT;
            if ({1'b0, it_rem_reg[k]} >= trial)
            begin
                rem_next  = QW'({1'b0, it_rem_reg[k]} - trial);
                root_next = QW'({1'b0, it_root_reg[k] >> 1} + BIT);
            end
            else
            begin
                rem_next  = it_rem_reg[k];
                root_next = it_root_reg[k] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                it_vld_reg[k+1] <= 1'b0;
            else
                it_vld_reg[k+1] <= it_vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            it_arr_reg[k+1]  <= it_arr_reg[k];
            it_zero_reg[k+1] <= it_zero_reg[k];
            it_x_reg[k+1]    <= x_next;
            it_y_reg[k+1]    <= y_next;
            it_z_reg[k+1]    <= z_next;
            it_rem_reg[k+1]  <= rem_next;
            it_root_reg[k+1] <= root_next;
            it_head_reg[k+1] <= it_head_reg[k];
        end
    end

    // ---------------- stage D: bearing rounding, heading error
    logic signed [ZW-1:0] d_zr;
    logic signed [17:0]   d_bearing;

    logic                 d_vld_reg, d_arr_reg;
    logic signed [18:0]   d_err_reg;
    logic [24:0]          d_dist_reg;

    always_comb
    begin
        d_zr      = it_z_reg[ITER] + ZW'(65536);
        d_bearing = it_zero_reg[ITER] ? 18'sd0 : d_zr[ZW-1:17];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_vld_reg <= 1'b0;
        else
            d_vld_reg <= it_vld_reg[ITER];
    end

    always_ff @(posedge clk)
    begin
        d_arr_reg  <= it_arr_reg[ITER];
        d_err_reg  <= {d_bearing[17], d_bearing} -
                      {{3{it_head_reg[ITER][15]}}, it_head_reg[ITER]};
        d_dist_reg <= it_root_reg[ITER][24:0];
    end

    // ---------------- stage E: wrap to [-pi, pi), magnitude
    logic signed [18:0] e_wrap;

    logic               e_vld_reg, e_arr_reg, e_neg_reg;
    logic [17:0]        e_ae_reg;
    logic [24:0]        e_dist_reg;

    always_comb
    begin
        if (d_err_reg >= ggvc_pkg::PI_Q13)
            e_wrap = d_err_reg - ggvc_pkg::TWO_PI_Q13;
        else if (d_err_reg < -ggvc_pkg::PI_Q13)
            e_wrap = d_err_reg + ggvc_pkg::TWO_PI_Q13;
        else
            e_wrap = d_err_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_vld_reg <= 1'b0;
        else
            e_vld_reg <= d_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        e_arr_reg  <= d_arr_reg;
        e_neg_reg  <= e_wrap[18];
        e_ae_reg   <= e_wrap[18] ? 18'(-e_wrap) : 18'(e_wrap);
        e_dist_reg <= d_dist_reg;
    end

    // ---------------- stage F: gain products
    logic               f_vld_reg, f_arr_reg, f_neg_reg, f_fwd_reg;
    logic [33:0]        f_wprod_reg;
    logic [40:0]        f_lprod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_vld_reg <= 1'b0;
        else
            f_vld_reg <= e_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        f_arr_reg   <= e_arr_reg;
        f_neg_reg   <= e_neg_reg;
        f_fwd_reg   <= e_ae_reg < {4'd0, cfg.heading_margin};
        f_wprod_reg <= 34'(cfg.angular_gain) * 34'(e_ae_reg);
        f_lprod_reg <= 41'(cfg.linear_gain) * 41'(e_dist_reg);
    end

    // ---------------- stage G: floors, saturation, output register
    logic [17:0]        g_w, g_wmin, g_wm;
    logic [14:0]        g_wc;
    logic [24:0]        g_l, g_lm;
    logic [22:0]        g_lc;
    ggvc_pkg::cmd_t     result_next;

    logic               done_reg;
    ggvc_pkg::cmd_t     result_reg;

    always_comb
    begin
        g_w    = f_wprod_reg[33:16];
        g_wmin = {5'd0, cfg.angular_gain[15:3]};
        g_wm   = (g_w < g_wmin) ? g_wmin : g_w;
        g_wc   = (g_wm > 18'd32767) ? 15'h7FFF : g_wm[14:0];
        g_l    = f_lprod_reg[40:16];
        g_lm   = (g_l < {9'd0, cfg.linear_gain}) ? {9'd0, cfg.linear_gain} : g_l;
        g_lc   = (g_lm > 25'd8388607) ? 23'h7FFFFF : g_lm[22:0];

        if (f_arr_reg)
        begin
            result_next.linear_velocity  = '0;
            result_next.angular_velocity = '0;
            result_next.arrived          = 1'b1;
        end
        else
        begin
            result_next.linear_velocity  = f_fwd_reg ? {1'b0, g_lc} : 24'sd0;
            result_next.angular_velocity = f_neg_reg ? -{1'b0, g_wc} : {1'b0, g_wc};
            result_next.arrived          = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= f_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ---------------- checks
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(ggvc_pkg::LATENCY) done)
        else $error("item did not complete at fixed latency");

    a_arrived_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.arrived) |->
            (result.linear_velocity == '0) && (result.angular_velocity == '0))
        else $error("arrived item with nonzero command");

    a_linear_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.arrived && result.linear_velocity != '0) |->
            (result.linear_velocity >= $signed({8'd0, cfg.linear_gain})))
        else $error("linear command below minimum speed");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready && cfg_index == ggvc_pkg::REG_GOAL_X) |=>
            (cfg.goal_x == $past(cfg_data)))
        else $error("goal_x write lost");

endmodule

// File: design/ggvc_cfg.sv
// Configuration register file of the go-to-goal velocity controller.
module ggvc_cfg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [2:0]        wr_index,
    input  logic [23:0]       wr_data,
    output ggvc_pkg::cfg_t    cfg
);

    ggvc_pkg::cfg_t cfg_reg;
    ggvc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                ggvc_pkg::REG_GOAL_X:          cfg_next.goal_x = wr_data;
                ggvc_pkg::REG_GOAL_Y:          cfg_next.goal_y = wr_data;
                ggvc_pkg::REG_POSITION_MARGIN: cfg_next.position_margin = wr_data[15:0];
                ggvc_pkg::REG_HEADING_MARGIN:  cfg_next.heading_margin = wr_data[13:0];
                ggvc_pkg::REG_ANGULAR_GAIN:    cfg_next.angular_gain = wr_data[15:0];
                ggvc_pkg::REG_LINEAR_GAIN:     cfg_next.linear_gain = wr_data[15:0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.goal_x          <= '0;
            cfg_reg.goal_y          <= '0;
            cfg_reg.position_margin <= 16'd3277;
            cfg_reg.heading_margin  <= 14'd410;
            cfg_reg.angular_gain    <= 16'd6554;
            cfg_reg.linear_gain     <= 16'd6554;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
